// ----- rtl/i2c_master_register_transfer_top_defines.svh -----
// ----------------------------------------------------------------------------
// I2C master register transfer assertion macros
// Shared property forms for the port checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_TRANSFER_TOP_DEFINES_SVH
`define I2C_MASTER_REGISTER_TRANSFER_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master register transfer package
// Phase and step codes, command and status codes, and the word types.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_PROBE = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ADDR_NACK = 2'd1;
  localparam logic [1:0] STAT_DATA_NACK = 2'd2;
  localparam logic [1:0] STAT_BUS_BUSY  = 2'd3;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd251;
  localparam logic [3:0] BIT_LAST          = 4'd7;

  typedef enum logic [15:0] {
    PH_IDLE      = 16'h0001,
    PH_START_A   = 16'h0002,
    PH_START_B   = 16'h0004,
    PH_START_C   = 16'h0008,
    PH_TX_LOW    = 16'h0010,
    PH_TX_HIGH   = 16'h0020,
    PH_ACK_LOW   = 16'h0040,
    PH_ACK_HIGH  = 16'h0080,
    PH_RX_LOW    = 16'h0100,
    PH_RX_HIGH   = 16'h0200,
    PH_MACK_LOW  = 16'h0400,
    PH_MACK_HIGH = 16'h0800,
    PH_STOP_A    = 16'h1000,
    PH_STOP_B    = 16'h2000,
    PH_STOP_C    = 16'h4000,
    PH_RS_PREP   = 16'h8000
  } phase_t;

  typedef enum logic [2:0] {
    STEP_DEV    = 3'd0,
    STEP_REG    = 3'd1,
    STEP_DEV_RD = 3'd2,
    STEP_DATA   = 3'd3,
    STEP_RDATA  = 3'd4,
    STEP_PROBE  = 3'd5
  } step_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  device_address;
    logic [7:0]  register_address;
    logic [15:0] byte_count;
    logic [7:0]  tx_byte;
    logic        sda_sample;
    logic        scl_sample;
  } item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       tx_take;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/i2c_master_register_transfer_top.sv -----
// A tick word is held in the input register and its result in the result
// register. Throughput: one tick word per cycle while out_stall is low; the
// bus sequencer takes one phase step per cycle from its input register into
// the result register. Reset (rst, synchronous, active high) puts the
// sequencer in idle, empties both registers and sets the ACK timeout to 251.
// ----------------------------------------------------------------------------
// I2C master register transfer top level
// Open-drain I2C master for register writes, reads and probes, one half-bit
// phase per tick word.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_register_transfer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  device_address,
  input  wire logic [7:0]  register_address,
  input  wire logic [15:0] byte_count,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        sda_sample,
  input  wire logic        scl_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             scl_drive,
  output logic             sda_drive,
  output logic             tx_take,
  output logic [7:0]       rx_byte,
  output logic             rx_valid,
  output logic             busy_res,
  output logic             done_res,
  output logic [1:0]       status
);

  i2cm_pkg::item_t   in_item;
  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t res;
  i2cm_pkg::result_t res_q;
  logic              item_valid;
  logic              room;
  logic              fire;

  always_comb begin
    in_item.command          = command;
    in_item.device_address   = device_address;
    in_item.register_address = register_address;
    in_item.byte_count       = byte_count;
    in_item.tx_byte          = tx_byte;
    in_item.sda_sample       = sda_sample;
    in_item.scl_sample       = scl_sample;
  end

  assign fire = item_valid && room;

  i2cm_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (room)
  );

  i2cm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .res       (res)
  );

  i2cm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (res_q)
  );

  assign scl_drive = res_q.scl_drive;
  assign sda_drive = res_q.sda_drive;
  assign tx_take   = res_q.tx_take;
  assign rx_byte   = res_q.rx_byte;
  assign rx_valid  = res_q.rx_valid;
  assign busy_res  = res_q.busy_res;
  assign done_res  = res_q.done_res;
  assign status    = res_q.status;

endmodule

`default_nettype wire

// ----- rtl/i2cm_in_stage.sv -----
// ----------------------------------------------------------------------------
// I2C master input register
// Holds one accepted tick word until the sequencer consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire i2cm_pkg::item_t in_item,
  output logic               item_valid,
  output i2cm_pkg::item_t    item,
  input  wire logic          item_take
);

  assign in_stall = item_valid && !item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Advances the bus phase by one tick per consumed word and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_wdata,
  input  wire logic            fire,
  input  wire i2cm_pkg::item_t item,
  output i2cm_pkg::result_t    res
);

  i2cm_pkg::phase_t phase, phase_next;
  i2cm_pkg::step_t  step, step_next;
  logic [1:0]  op_kind, op_kind_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  wait_count, wait_count_next;
  logic [7:0]  saved_device, saved_device_next;
  logic [7:0]  saved_register, saved_register_next;
  logic        resume, resume_next;
  logic [1:0]  final_code, final_code_next;
  logic [7:0]  ack_timeout;
  logic        do_next;
  logic        take;
  logic [7:0]  rxb;
  logic        rxv;
  logic        done;
  logic [1:0]  stat;
  logic        scl_o;
  logic        sda_o;

  always_comb begin
    phase_next          = phase;
    step_next           = step;
    op_kind_next        = op_kind;
    shift_reg_next      = shift_reg;
    bit_index_next      = bit_index;
    bytes_left_next     = bytes_left;
    wait_count_next     = wait_count;
    saved_device_next   = saved_device;
    saved_register_next = saved_register;
    resume_next         = resume;
    final_code_next     = final_code;
    do_next             = 1'b0;
    take                = 1'b0;
    rxb                 = 8'd0;
    rxv                 = 1'b0;
    done                = 1'b0;
    stat                = i2cm_pkg::STAT_OK;

    unique case (phase)
      i2cm_pkg::PH_IDLE: begin
        if (item.command != i2cm_pkg::CMD_NONE) begin
          if (item.command == i2cm_pkg::CMD_PROBE &&
              !(item.sda_sample && item.scl_sample)) begin
            done = 1'b1;
            stat = i2cm_pkg::STAT_BUS_BUSY;
          end else begin
            op_kind_next        = item.command;
            saved_device_next   = item.device_address;
            saved_register_next = item.register_address;
            bytes_left_next     = item.byte_count;
            step_next           = (item.command == i2cm_pkg::CMD_PROBE) ?
                                  i2cm_pkg::STEP_PROBE : i2cm_pkg::STEP_DEV;
            resume_next         = 1'b0;
            final_code_next     = i2cm_pkg::STAT_OK;
            phase_next          = i2cm_pkg::PH_START_A;
          end
        end
      end
      i2cm_pkg::PH_RS_PREP: phase_next = i2cm_pkg::PH_START_A;
      i2cm_pkg::PH_START_A: phase_next = i2cm_pkg::PH_START_B;
      i2cm_pkg::PH_START_B: phase_next = i2cm_pkg::PH_START_C;
      i2cm_pkg::PH_START_C: begin
        if (step == i2cm_pkg::STEP_PROBE) begin
          shift_reg_next = saved_register;
        end else if (step == i2cm_pkg::STEP_DEV_RD) begin
          shift_reg_next = saved_device + 8'd1;
        end else begin
          shift_reg_next = saved_device;
        end
        bit_index_next = 4'd0;
        phase_next     = i2cm_pkg::PH_TX_LOW;
      end
      i2cm_pkg::PH_TX_LOW: phase_next = i2cm_pkg::PH_TX_HIGH;
      i2cm_pkg::PH_TX_HIGH: begin
        shift_reg_next = {shift_reg[6:0], 1'b0};
        bit_index_next = bit_index + 4'd1;
        phase_next     = (bit_index_next > i2cm_pkg::BIT_LAST) ?
                         i2cm_pkg::PH_ACK_LOW : i2cm_pkg::PH_TX_LOW;
      end
      i2cm_pkg::PH_ACK_LOW: begin
        wait_count_next = 8'd0;
        phase_next      = i2cm_pkg::PH_ACK_HIGH;
      end
      i2cm_pkg::PH_ACK_HIGH: begin
        if (!item.sda_sample) begin
          do_next = 1'b1;
        end else if (wait_count >= ack_timeout) begin
          phase_next = i2cm_pkg::PH_STOP_A;
          unique case (step)
            i2cm_pkg::STEP_DEV, i2cm_pkg::STEP_PROBE: begin
              resume_next     = 1'b0;
              final_code_next = i2cm_pkg::STAT_ADDR_NACK;
            end
            i2cm_pkg::STEP_DATA: begin
              resume_next     = 1'b0;
              final_code_next = i2cm_pkg::STAT_DATA_NACK;
            end
            default: begin
              resume_next     = 1'b1;
              final_code_next = i2cm_pkg::STAT_OK;
            end
          endcase
        end else begin
          wait_count_next = wait_count + 8'd1;
        end
      end
      i2cm_pkg::PH_RX_LOW: phase_next = i2cm_pkg::PH_RX_HIGH;
      i2cm_pkg::PH_RX_HIGH: begin
        shift_reg_next = {shift_reg[6:0], item.sda_sample};
        bit_index_next = bit_index + 4'd1;
        if (bit_index_next > i2cm_pkg::BIT_LAST) begin
          rxb             = shift_reg_next;
          rxv             = 1'b1;
          bytes_left_next = bytes_left - 16'd1;
          phase_next      = i2cm_pkg::PH_MACK_LOW;
        end else begin
          phase_next = i2cm_pkg::PH_RX_LOW;
        end
      end
      i2cm_pkg::PH_MACK_LOW: phase_next = i2cm_pkg::PH_MACK_HIGH;
      i2cm_pkg::PH_MACK_HIGH: begin
        if (bytes_left != 16'd0) begin
          bit_index_next = 4'd0;
          shift_reg_next = 8'd0;
          phase_next     = i2cm_pkg::PH_RX_LOW;
        end else begin
          resume_next     = 1'b0;
          final_code_next = i2cm_pkg::STAT_OK;
          phase_next      = i2cm_pkg::PH_STOP_A;
        end
      end
      i2cm_pkg::PH_STOP_A: phase_next = i2cm_pkg::PH_STOP_B;
      i2cm_pkg::PH_STOP_B: phase_next = i2cm_pkg::PH_STOP_C;
      i2cm_pkg::PH_STOP_C: begin
        if (resume) begin
          resume_next = 1'b0;
          do_next     = 1'b1;
        end else begin
          phase_next = i2cm_pkg::PH_IDLE;
          done       = 1'b1;
          stat       = final_code;
        end
      end
      default: phase_next = i2cm_pkg::PH_IDLE;
    endcase

    // After an acknowledged byte, or a stop that the transfer continues past,
    // the sequence moves on to its next step.
    if (do_next) begin
      unique case (step)
        i2cm_pkg::STEP_DEV: begin
          step_next      = i2cm_pkg::STEP_REG;
          shift_reg_next = saved_register;
          bit_index_next = 4'd0;
          phase_next     = i2cm_pkg::PH_TX_LOW;
        end
        i2cm_pkg::STEP_REG, i2cm_pkg::STEP_DATA: begin
          if (step == i2cm_pkg::STEP_REG && op_kind == i2cm_pkg::CMD_READ) begin
            step_next  = i2cm_pkg::STEP_DEV_RD;
            phase_next = i2cm_pkg::PH_RS_PREP;
          end else if (bytes_left != 16'd0) begin
            step_next       = i2cm_pkg::STEP_DATA;
            bytes_left_next = bytes_left - 16'd1;
            take            = 1'b1;
            shift_reg_next  = item.tx_byte;
            bit_index_next  = 4'd0;
            phase_next      = i2cm_pkg::PH_TX_LOW;
          end else begin
            resume_next     = 1'b0;
            final_code_next = i2cm_pkg::STAT_OK;
            phase_next      = i2cm_pkg::PH_STOP_A;
          end
        end
        i2cm_pkg::STEP_DEV_RD: begin
          if (bytes_left != 16'd0) begin
            step_next      = i2cm_pkg::STEP_RDATA;
            bit_index_next = 4'd0;
            shift_reg_next = 8'd0;
            phase_next     = i2cm_pkg::PH_RX_LOW;
          end else begin
            resume_next     = 1'b0;
            final_code_next = i2cm_pkg::STAT_OK;
            phase_next      = i2cm_pkg::PH_STOP_A;
          end
        end
        default: begin
          resume_next     = 1'b0;
          final_code_next = i2cm_pkg::STAT_OK;
          phase_next      = i2cm_pkg::PH_STOP_A;
        end
      endcase
    end
  end

  always_comb begin
    unique case (phase_next)
      i2cm_pkg::PH_START_B: begin
        scl_o = 1'b1;
        sda_o = 1'b0;
      end
      i2cm_pkg::PH_START_C, i2cm_pkg::PH_STOP_A: begin
        scl_o = 1'b0;
        sda_o = 1'b0;
      end
      i2cm_pkg::PH_TX_LOW: begin
        scl_o = 1'b0;
        sda_o = shift_reg_next[7];
      end
      i2cm_pkg::PH_TX_HIGH: begin
        scl_o = 1'b1;
        sda_o = shift_reg_next[7];
      end
      i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_RX_LOW, i2cm_pkg::PH_RS_PREP: begin
        scl_o = 1'b0;
        sda_o = 1'b1;
      end
      i2cm_pkg::PH_MACK_LOW: begin
        scl_o = 1'b0;
        sda_o = (bytes_left_next == 16'd0);
      end
      i2cm_pkg::PH_MACK_HIGH: begin
        scl_o = 1'b1;
        sda_o = (bytes_left_next == 16'd0);
      end
      i2cm_pkg::PH_STOP_B: begin
        scl_o = 1'b1;
        sda_o = 1'b0;
      end
      default: begin
        scl_o = 1'b1;
        sda_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    res.scl_drive = scl_o;
    res.sda_drive = sda_o;
    res.tx_take   = take;
    res.rx_byte   = rxb;
    res.rx_valid  = rxv;
    res.busy_res  = (phase_next != i2cm_pkg::PH_IDLE);
    res.done_res  = done;
    res.status    = stat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      ack_timeout <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cm_pkg::PH_IDLE;
      step           <= i2cm_pkg::STEP_DEV;
      op_kind        <= i2cm_pkg::CMD_NONE;
      shift_reg      <= 8'd0;
      bit_index      <= 4'd0;
      bytes_left     <= 16'd0;
      wait_count     <= 8'd0;
      saved_device   <= 8'd0;
      saved_register <= 8'd0;
      resume         <= 1'b0;
      final_code     <= i2cm_pkg::STAT_OK;
    end else if (fire) begin
      phase          <= phase_next;
      step           <= step_next;
      op_kind        <= op_kind_next;
      shift_reg      <= shift_reg_next;
      bit_index      <= bit_index_next;
      bytes_left     <= bytes_left_next;
      wait_count     <= wait_count_next;
      saved_device   <= saved_device_next;
      saved_register <= saved_register_next;
      resume         <= resume_next;
      final_code     <= final_code_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2cm_out_stage.sv -----
// ----------------------------------------------------------------------------
// I2C master result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire i2cm_pkg::result_t res_in,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output i2cm_pkg::result_t      res_q
);

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2c_master_register_transfer_checker.sv -----
// ----------------------------------------------------------------------------
// I2C master register transfer port checker
// Watches the top level ports for result word consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_register_transfer_top_defines.svh"

module i2c_master_register_transfer_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        scl_drive,
  input wire logic        sda_drive,
  input wire logic        tx_take,
  input wire logic [7:0]  rx_byte,
  input wire logic        rx_valid,
  input wire logic        busy_res,
  input wire logic        done_res,
  input wire logic [1:0]  status
);

  logic [15:0] word;

  assign word = {scl_drive, sda_drive, tx_take, rx_byte, rx_valid, busy_res,
                 done_res, status};

  `I2CM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(word), "stalled result word changed")
  `I2CM_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res, "transfer finished while still busy")
  `I2CM_ASSERT_NOW(a_rx_busy, out_valid && rx_valid, busy_res && !scl_drive, "received byte outside a transfer")
  `I2CM_ASSERT_NOW(a_take_bit, out_valid && tx_take, busy_res && !scl_drive && !done_res, "data byte taken outside a bit phase")
  `I2CM_ASSERT_NOW(a_status_done, out_valid && (status != i2cm_pkg::STAT_OK), done_res, "status reported without finish")

endmodule

bind i2c_master_register_transfer_top i2c_master_register_transfer_checker u_checker (.*);

`default_nettype wire
